>>> hdl/dbp_pkg.sv
package dbp_pkg;

  localparam int unsigned OffW = 17;
  localparam int unsigned RecW = 18;
  localparam logic [OffW-1:0] BlockLenReset = 17'd4096;
  localparam logic [15:0] RecLenMask = 16'd65532;
  localparam logic [7:0] HdrBytes = 8'd8;
  localparam logic [7:0] DotChar = 8'h2e;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = 2;
  localparam int unsigned QueueCntW = 3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_PAD    = 2'd2
  } phase_e;

  // one queued word: a single result, or a pair whose first byte is held
  typedef struct packed {
    logic        pair;
    logic [7:0]  held;
    logic [31:0] inode;
    logic [7:0]  ftype;
    logic [7:0]  nlen;
    logic [7:0]  idx;
    logic [7:0]  ch;
    logic        last;
  } res_t;

endpackage

>>> hdl/dbp_front.sv
module dbp_front #(
  parameter int unsigned MAX_BLOCK_BYTES = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       cfg_we_i,
  input  logic [dbp_pkg::OffW-1:0]   cfg_wdata_i,
  output logic                       push_o,
  output dbp_pkg::res_t              push_word_o
);

  localparam logic [dbp_pkg::OffW-1:0] MaxLen = dbp_pkg::OffW'(MAX_BLOCK_BYTES);

  logic [dbp_pkg::OffW-1:0] blen_q;
  logic [dbp_pkg::OffW-1:0] off_q, off_d, start_q, start_d;
  logic [dbp_pkg::RecW-1:0] rec_q, rec_d;
  logic [31:0] inode_q, inode_d;
  logic [7:0]  nlen_q, nlen_d, type_q, type_d, held_q, held_d;
  dbp_pkg::phase_e phase_q, phase_d;
  logic stop_q, stop_d;

  logic [dbp_pkg::OffW-1:0] len;
  logic [dbp_pkg::OffW-1:0] rel;
  logic [dbp_pkg::OffW:0]   o1;
  logic [7:0]  k;
  logic [8:0]  k1;
  logic [15:0] raw;
  logic [dbp_pkg::RecW-1:0] dec;
  logic        bad;
  logic [7:0]  b;

  assign b   = data_byte_i;
  assign len = (blen_q > MaxLen) ? MaxLen : blen_q;
  assign o1  = {1'b0, off_q} + 18'd1;
  assign rel = off_q - start_q;
  assign k   = rel[7:0] - dbp_pkg::HdrBytes;
  assign k1  = {1'b0, k} + 9'd1;
  assign raw = rec_q[15:0];
  // low two raw bits carry length bits 17:16
  assign dec = {raw[1:0], raw & dbp_pkg::RecLenMask};
  assign bad = (raw == 16'hffff) || (raw == 16'h0000) || (dec < 18'd8) ||
               ({2'b00, start_q} + {1'b0, dec} > {2'b00, len}) ||
               ({10'd0, nlen_q} + {10'd0, dbp_pkg::HdrBytes} > dec);

  always_comb begin
    off_d   = off_q;
    start_d = start_q;
    rec_d   = rec_q;
    inode_d = inode_q;
    nlen_d  = nlen_q;
    type_d  = type_q;
    held_d  = held_q;
    phase_d = phase_q;
    stop_d  = stop_q;
    push_o  = 1'b0;
    push_word_o.pair  = 1'b0;
    push_word_o.held  = held_q;
    push_word_o.inode = inode_q;
    push_word_o.ftype = type_q;
    push_word_o.nlen  = nlen_q;
    push_word_o.idx   = 8'd0;
    push_word_o.ch    = b;
    push_word_o.last  = 1'b1;
    if (accept_i) begin
      if (!stop_q) begin
        unique case (phase_q)
          dbp_pkg::PH_HEADER: begin
            if (rel == '0 && ({1'b0, start_q} + 18'd8 >= {1'b0, len})) begin
              stop_d = 1'b1;
            end else begin
              unique case (rel[2:0])
                3'd0: inode_d = {24'd0, b};
                3'd1: inode_d[15:8] = b;
                3'd2: inode_d[23:16] = b;
                3'd3: inode_d[31:24] = b;
                3'd4: rec_d = {10'd0, b};
                3'd5: rec_d[15:8] = b;
                3'd6: nlen_d = b;
                default: begin
                  type_d = b;
                  if (bad) begin
                    stop_d = 1'b1;
                  end else begin
                    rec_d   = dec;
                    phase_d = (inode_q == '0 || nlen_q == '0) ? dbp_pkg::PH_PAD
                                                              : dbp_pkg::PH_NAME;
                  end
                end
              endcase
            end
          end
          dbp_pkg::PH_NAME: begin
            if (nlen_q == 8'd1) begin
              push_o  = (b != dbp_pkg::DotChar);
              phase_d = dbp_pkg::PH_PAD;
            end else if (nlen_q == 8'd2) begin
              if (k == 8'd0) begin
                held_d = b;
              end else begin
                // both bytes go out together unless the name is dot-dot
                push_o = !(held_q == dbp_pkg::DotChar && b == dbp_pkg::DotChar);
                push_word_o.pair = 1'b1;
                push_word_o.idx  = 8'd1;
                phase_d = dbp_pkg::PH_PAD;
              end
            end else begin
              push_o = 1'b1;
              push_word_o.idx  = k;
              push_word_o.last = (k1 == {1'b0, nlen_q});
              if (k1 == {1'b0, nlen_q}) begin
                phase_d = dbp_pkg::PH_PAD;
              end
            end
          end
          default: begin
          end
        endcase
        if (!stop_d && phase_d != dbp_pkg::PH_HEADER &&
            {1'b0, o1} == {2'b00, start_q} + {1'b0, rec_d}) begin
          start_d = o1[dbp_pkg::OffW-1:0];
          phase_d = dbp_pkg::PH_HEADER;
        end
      end
      if (o1 >= {1'b0, len}) begin
        off_d   = '0;
        start_d = '0;
        rec_d   = '0;
        inode_d = '0;
        nlen_d  = '0;
        type_d  = '0;
        held_d  = '0;
        phase_d = dbp_pkg::PH_HEADER;
        stop_d  = 1'b0;
      end else begin
        off_d = o1[dbp_pkg::OffW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q  <= dbp_pkg::BlockLenReset;
      off_q   <= '0;
      start_q <= '0;
      rec_q   <= '0;
      inode_q <= '0;
      nlen_q  <= '0;
      type_q  <= '0;
      held_q  <= '0;
      phase_q <= dbp_pkg::PH_HEADER;
      stop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blen_q <= cfg_wdata_i;
      end
      off_q   <= off_d;
      start_q <= start_d;
      rec_q   <= rec_d;
      inode_q <= inode_d;
      nlen_q  <= nlen_d;
      type_q  <= type_d;
      held_q  <= held_d;
      phase_q <= phase_d;
      stop_q  <= stop_d;
    end
  end

endmodule

>>> hdl/dbp_queue.sv
module dbp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dbp_pkg::res_t push_word_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output dbp_pkg::res_t head_o
);

  dbp_pkg::res_t mem_q [dbp_pkg::QueueDepth];
  logic [dbp_pkg::QueueAw-1:0] wr_q, rd_q;
  logic [dbp_pkg::QueueCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == dbp_pkg::QueueCntW'(dbp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + dbp_pkg::QueueCntW'(do_push) - dbp_pkg::QueueCntW'(do_pop);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("word pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dbp_pkg::QueueCntW'(dbp_pkg::QueueDepth))
    else $error("queue count out of range");

endmodule

>>> hdl/dbp_back.sv
module dbp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  dbp_pkg::res_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   entry_inode_o,
  output logic [7:0]    entry_type_o,
  output logic [7:0]    name_length_o,
  output logic [7:0]    char_index_o,
  output logic [7:0]    name_char_o,
  output logic          last_of_name_o
);

  logic valid_q, half_q, load;
  logic first_half;

  assign load       = q_valid_i && (!valid_q || out_ready_i);
  assign first_half = head_i.pair && !half_q;
  assign pop_o      = load && !first_half;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        half_q  <= first_half;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_inode_o  <= head_i.inode;
      entry_type_o   <= head_i.ftype;
      name_length_o  <= head_i.nlen;
      // pair word: held byte first at index zero, then the stored byte
      char_index_o   <= first_half ? 8'd0 : head_i.idx;
      name_char_o    <= first_half ? head_i.held : head_i.ch;
      last_of_name_o <= first_half ? 1'b0 : head_i.last;
    end
  end

  a_half_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> valid_q)
    else $error("pair half pending without a word on the output");

  a_pair_pop_after_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.pair) |-> half_q)
    else $error("pair word popped before its first byte went out");

endmodule

>>> hdl/ext2_dir_block_parser.sv
// path: a name byte is written into the queue, then registered in the output stage;
//   the second byte of a two-byte name follows the first out of the same queue word
// throughput: one input word per cycle while the queue is not full, one result word
//   per cycle while out_ready_i is high; the 4-entry queue between parser and output
//   stage absorbs the two-result words, which always follow a word with no result
// reset: parse state cleared, block_length back to 4096, no clearing pass
module ext2_dir_block_parser #(
  parameter int unsigned MAX_BLOCK_BYTES = 65536
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     block_length_we_i,
  input  logic [dbp_pkg::OffW-1:0] block_length_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [31:0]              entry_inode_o,
  output logic [7:0]               entry_type_o,
  output logic [7:0]               name_length_o,
  output logic [7:0]               char_index_o,
  output logic [7:0]               name_char_o,
  output logic                     last_of_name_o
);

  logic          push, full, q_valid, pop;
  dbp_pkg::res_t push_word, head;

  assign in_ready_o = !full;

  dbp_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_valid_i && in_ready_o),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (block_length_we_i),
    .cfg_wdata_i (block_length_i),
    .push_o      (push),
    .push_word_o (push_word)
  );

  dbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .head_o      (head)
  );

  dbp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_inode_o  (entry_inode_o),
    .entry_type_o   (entry_type_o),
    .name_length_o  (name_length_o),
    .char_index_o   (char_index_o),
    .name_char_o    (name_char_o),
    .last_of_name_o (last_of_name_o)
  );

endmodule
